FILE: design/atiu_pkg.sv
// Shared constants, types and the front-end step table of the affine inverse unit.
package atiu_pkg;

	localparam int DW    = 32;             // entry width
	localparam int FB    = 16;             // fraction bits
	localparam int NIN   = 12;             // entries in one input word
	localparam int OPW   = DW + 1;         // multiplier operand width
	localparam int PW    = 2 * OPW;        // product width
	localparam int ADW   = 2 * DW + 1;     // adjugate entry width
	localparam int ACW   = 3 * DW + 4;     // determinant / translation numerator width
	localparam int QB    = DW + 1;         // quotient bits produced by the divider
	localparam int QBX   = (DW + 1 > 2 * FB + 1) ? DW + 1 : 2 * FB + 1;
	localparam int NW    = ACW + QBX + 2;  // divider remainder width
	localparam int CNW   = $clog2(QB);
	localparam int NSTEP = 42;             // multiply steps per transform
	localparam int STW   = $clog2(NSTEP);
	localparam int ST_ADJ_END = 18;
	localparam int ST_DET_END = 24;
	localparam int IN_TW  = ((NIN * DW + 7) / 8) * 8;
	localparam int OUT_TW = ((3 * DW + 7) / 8) * 8;
	localparam int USR_W  = 3;

	localparam logic [3:0] DEST_DET = 4'd9;
	localparam logic [3:0] DEST_TN0 = 4'd10;
	localparam logic [1:0] COL_T    = 2'd3;

	// adj[j] = m[A]*m[B] - m[C]*m[D], indices are column*3 + row
	localparam logic [3:0] ADJ_A [9] = '{4'd4, 4'd6, 4'd3, 4'd7, 4'd0, 4'd6, 4'd1, 4'd3, 4'd0};
	localparam logic [3:0] ADJ_B [9] = '{4'd8, 4'd5, 4'd7, 4'd2, 4'd8, 4'd1, 4'd5, 4'd2, 4'd4};
	localparam logic [3:0] ADJ_C [9] = '{4'd7, 4'd3, 4'd6, 4'd1, 4'd6, 4'd0, 4'd4, 4'd0, 4'd3};
	localparam logic [3:0] ADJ_D [9] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd2, 4'd7, 4'd2, 4'd5, 4'd1};
	localparam logic [3:0] DIV3  [9] = '{4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2};
	localparam logic [3:0] MOD3  [9] = '{4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2};

	typedef enum logic [1:0] {
		B_IN = 2'd0,
		B_LO = 2'd1,
		B_HI = 2'd2
	} bsel_t;

	typedef struct packed {
		logic [3:0] a_idx;
		bsel_t      b_kind;
		logic [3:0] b_idx;
		logic       first;
		logic       neg;
		logic       last;
		logic       shift;
		logic [3:0] dest;
	} step_t;

	typedef struct packed {
		logic [8:0][ADW-1:0] adj;
		logic [2:0][ACW-1:0] tn;
		logic [ACW-1:0]      det;
	} entry_t;

	typedef struct packed {
		logic idle;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic          sing;
		logic [1:0]    col;
		logic [DW-1:0] z;
		logic [DW-1:0] y;
		logic [DW-1:0] x;
	} res_t;

	function automatic step_t step_decode(input logic [STW-1:0] s);
		step_t d;
		logic [STW-1:0] u;
		logic [3:0] j;
		d = '0;
		if (s < STW'(ST_ADJ_END)) begin
			j        = 4'(s >> 1);
			d.b_kind = B_IN;
			d.a_idx  = s[0] ? ADJ_C[j] : ADJ_A[j];
			d.b_idx  = s[0] ? ADJ_D[j] : ADJ_B[j];
			d.first  = ~s[0];
			d.neg    = s[0];
			d.last   = s[0];
			d.dest   = j;
		end else if (s < STW'(ST_DET_END)) begin
			u        = s - STW'(ST_ADJ_END);
			j        = 4'(u >> 1);
			d.a_idx  = j * 4'd3;
			d.b_idx  = j * 4'd3;
			d.b_kind = u[0] ? B_HI : B_LO;
			d.shift  = u[0];
			d.first  = (u == '0);
			d.last   = (u == STW'(5));
			d.dest   = DEST_DET;
		end else begin
			u        = s - STW'(ST_DET_END);
			j        = 4'(u >> 1);
			d.a_idx  = 4'd9 + MOD3[j];
			d.b_idx  = j;
			d.b_kind = u[0] ? B_HI : B_LO;
			d.shift  = u[0];
			d.first  = (MOD3[j] == 4'd0) && !u[0];
			d.last   = (MOD3[j] == 4'd2) && u[0];
			d.neg    = 1'b1;
			d.dest   = DEST_TN0 + DIV3[j];
		end
		return d;
	endfunction

endpackage

FILE: design/affine_transform_inverse_unit.sv
// Top level of the 3D affine transform inverse unit.
//
// Input channel s_axis: one word per transform, twelve signed Q16.16 entries
// (linear columns 0..2 row by row, then the translation). Output channel
// m_axis: four words per transform, columns 0, 1, 2 of the inverse linear part
// and then the new translation, tlast on the translation word. tuser carries
// the column number and the singular flag; a singular transform gives zero
// entries on all four words.
//
// The front end runs 42 steps of one shared 33x33 multiplier to form the
// adjugate, the determinant and the translation numerators, then drops
// them into a two-entry queue. The back end runs three restoring dividers,
// one per row, one quotient bit per cycle. The front end takes the next
// transform while the back end still divides.
//
// Reset clears all handshake state; the queue and output register empty.
// A stalled receiver holds the output word; the dividers then wait finished
// and the queue fills, after which s_axis_tready drops.
module affine_transform_inverse_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z, shift_x, shift_y, shift_z
	input  logic [atiu_pkg::IN_TW-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// out_x, out_y, out_z
	output logic [atiu_pkg::OUT_TW-1:0] m_axis_tdata,
	// column, singular
	output logic [atiu_pkg::USR_W-1:0]  m_axis_tuser,
	output logic                        m_axis_tlast
);
	import atiu_pkg::*;

	logic push_valid, push_ready, pop_valid, pop;
	entry_t push_entry, pop_entry;
	res_t res;

	atiu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// decouples the multiplier front end from the divider back end
	atiu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	atiu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// pack the result word; tdata padding is zero
	assign m_axis_tdata = OUT_TW'({res.z, res.y, res.x});
	assign m_axis_tuser = {res.sing, res.col};
	assign m_axis_tlast = (res.col == COL_T);

endmodule

FILE: design/atiu_front.sv
// Front end: accepts a transform and forms adjugate, determinant and translation numerators.
module atiu_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [atiu_pkg::IN_TW-1:0] in_data,
	output logic                       push_valid,
	input  logic                       push_ready,
	output atiu_pkg::entry_t           push_entry
);
	import atiu_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE  = 4'b0001,
		F_RUN   = 4'b0010,
		F_DRAIN = 4'b0100,
		F_PUSH  = 4'b1000
	} fstate_t;

	fstate_t state_q;
	logic [STW-1:0] step_q;
	logic [NIN-1:0][DW-1:0] opnd_q;
	step_t st, ctl_s1;
	logic vld_s1;
	logic signed [OPW-1:0] a_op, b_op;
	logic signed [PW-1:0] prod_s1;
	logic signed [ACW-1:0] acc_q, term, acc_nx;
	entry_t entry_q;
	logic [1:0] ti;

	assign st = step_decode(step_q);
	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_entry = entry_q;

	always_comb begin
		a_op = {opnd_q[st.a_idx][DW-1], opnd_q[st.a_idx]};
		case (st.b_kind)
			B_IN:    b_op = {opnd_q[st.b_idx][DW-1], opnd_q[st.b_idx]};
			B_LO:    b_op = {1'b0, entry_q.adj[st.b_idx][DW-1:0]};
			B_HI:    b_op = entry_q.adj[st.b_idx][ADW-1:DW];
			default: b_op = '0;
		endcase
	end

	always_comb begin
		term = ACW'(prod_s1);
		if (ctl_s1.shift) begin
			term = term <<< DW;
		end
		if (ctl_s1.first) begin
			acc_nx = ctl_s1.neg ? -term : term;
		end else begin
			acc_nx = ctl_s1.neg ? acc_q - term : acc_q + term;
		end
		ti = 2'(ctl_s1.dest - DEST_TN0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == F_RUN);
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_RUN;
						step_q  <= '0;
					end
				end
				F_RUN: begin
					step_q <= step_q + STW'(1);
					if (step_q == STW'(NSTEP - 1)) begin
						state_q <= F_DRAIN;
					end
				end
				F_DRAIN: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opnd_q <= in_data[NIN*DW-1:0];
		end
		prod_s1 <= PW'(a_op) * PW'(b_op);
		ctl_s1  <= st;
		if (vld_s1) begin
			acc_q <= acc_nx;
			if (ctl_s1.last) begin
				if (ctl_s1.dest < DEST_DET) begin
					entry_q.adj[ctl_s1.dest] <= acc_nx[ADW-1:0];
				end else if (ctl_s1.dest == DEST_DET) begin
					entry_q.det <= acc_nx;
				end else begin
					entry_q.tn[ti] <= acc_nx;
				end
			end
		end
	end

endmodule

FILE: design/atiu_fifo.sv
// Two-entry queue between the front end and the division back end.
module atiu_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  atiu_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop,
	output atiu_pkg::entry_t pop_entry
);
	import atiu_pkg::*;

	entry_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic do_push;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_entry  = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule

FILE: design/atiu_div.sv
// Restoring divider: rounded, saturated quotient of one numerator by the determinant.
module atiu_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            lin,
	input  logic signed [atiu_pkg::ACW-1:0] num,
	input  logic signed [atiu_pkg::ACW-1:0] den,
	input  logic                            ack,
	output atiu_pkg::div_stat_t             stat,
	output logic [atiu_pkg::DW-1:0]         quo
);
	import atiu_pkg::*;

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_CHK  = 4'b0010,
		D_RUN  = 4'b0100,
		D_DONE = 4'b1000
	} dstate_t;

	dstate_t state_q;
	logic [NW-1:0] rem_q, dsh_q, a_init;
	logic [ACW-1:0] absn, absd;
	logic [QB-1:0] q_q, lim, qs, qn;
	logic [CNW-1:0] cnt_q;
	logic neg_q, ovf_q, zero_q, ge;

	assign absn = num[ACW-1] ? ACW'(-num) : ACW'(num);
	assign absd = den[ACW-1] ? ACW'(-den) : ACW'(den);
	// 2*|n|*2^sh + |d|, divided by 2*|d|, rounds half away from zero
	assign a_init = (lin ? (NW'(absn) << (2 * FB + 1)) : (NW'(absn) << (FB + 1))) + NW'(absd);
	assign ge = (rem_q >= dsh_q);

	assign stat.idle = (state_q == D_IDLE);
	assign stat.done = (state_q == D_DONE);

	always_comb begin
		lim = (QB'(1) << (DW - 1)) - QB'(!neg_q);
		qs  = (ovf_q || (q_q > lim)) ? lim : q_q;
		qn  = neg_q ? -qs : qs;
		quo = zero_q ? '0 : qn[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= (absd == '0) ? D_DONE : D_CHK;
					end
				end
				D_CHK: begin
					state_q <= D_RUN;
					cnt_q   <= CNW'(QB - 1);
				end
				D_RUN: begin
					cnt_q <= cnt_q - CNW'(1);
					if (cnt_q == '0) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					if (ack) begin
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				rem_q  <= a_init;
				dsh_q  <= NW'(absd) << 1;
				neg_q  <= num[ACW-1] ^ den[ACW-1];
				zero_q <= (absd == '0);
				q_q    <= '0;
				ovf_q  <= 1'b0;
			end
			D_CHK: begin
				ovf_q <= (rem_q >= (dsh_q << QB));
				dsh_q <= dsh_q << (QB - 1);
			end
			D_RUN: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				q_q   <= {q_q[QB-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

endmodule

FILE: design/atiu_back.sv
// Back end: three row dividers walk the four result columns of the head queue entry.
module atiu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  atiu_pkg::entry_t pop_entry,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output atiu_pkg::res_t   out_res
);
	import atiu_pkg::*;

	div_stat_t stat [3];
	logic [DW-1:0] quo [3];
	logic [1:0] col_q;
	logic all_idle, all_done, start, load, ovld_q;
	res_t res_q;

	assign all_idle = stat[0].idle && stat[1].idle && stat[2].idle;
	assign all_done = stat[0].done && stat[1].done && stat[2].done;
	assign start    = pop_valid && all_idle;
	assign load     = all_done && (!ovld_q || out_ready);
	assign pop      = load && (col_q == COL_T);
	assign out_valid = ovld_q;
	assign out_res   = res_q;

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [ACW-1:0] num;
		assign num = (col_q == COL_T) ? pop_entry.tn[r]
			: ACW'(signed'(pop_entry.adj[r*3 + int'(col_q)]));
		atiu_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (start),
			.lin    (col_q != COL_T),
			.num    (num),
			.den    (pop_entry.det),
			.ack    (load),
			.stat   (stat[r]),
			.quo    (quo[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			col_q  <= '0;
		end else begin
			if (load) begin
				ovld_q <= 1'b1;
				col_q  <= col_q + 2'd1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.x    <= quo[0];
			res_q.y    <= quo[1];
			res_q.z    <= quo[2];
			res_q.col  <= col_q;
			res_q.sing <= (pop_entry.det == '0);
		end
	end

endmodule

FILE: design/atiu_checker.sv
// Port-level checker for the affine inverse unit, bound to the top level.
module atiu_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [atiu_pkg::OUT_TW-1:0] m_axis_tdata,
	input logic [atiu_pkg::USR_W-1:0]  m_axis_tuser,
	input logic                        m_axis_tlast
);
	import atiu_pkg::*;

	logic [1:0] col_exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_exp_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			col_exp_q <= col_exp_q + 2'd1;
		end
	end

	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[1:0] == col_exp_q))
		else $error("result column out of order");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == COL_T)))
		else $error("tlast not on translation column");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == '0))
		else $error("singular word with nonzero entries");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output word changed");

endmodule

bind affine_transform_inverse_unit atiu_checker u_atiu_checker (.*);

FILE: tb/sv/atiu_checker.sv
// Checker for the affine inverse unit: watches both channels, predicts the inverse, compares.
module atiu_scoreboard (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [atiu_pkg::IN_TW-1:0]  s_axis_tdata,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [atiu_pkg::OUT_TW-1:0] m_axis_tdata,
	input  logic [atiu_pkg::USR_W-1:0]  m_axis_tuser,
	input  logic                        m_axis_tlast,
	output int                          fail_count,
	output int                          pending,
	output int                          words_seen,
	output int                          singular_seen,
	output int                          saturated_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import atiu_pkg::*;

	typedef struct {
		logic [1:0]    col;
		logic [DW-1:0] x;
		logic [DW-1:0] y;
		logic [DW-1:0] z;
		logic          sing;
		logic          last;
	} column_t;

	column_t inverse_q[$];

	localparam logic signed [DW-1:0] SAT_HI = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_LO = {1'b1, {(DW-1){1'b0}}};

	// round(num * 2^sh / den), ties away from zero, saturated
	function automatic logic [DW-1:0] quot_round(input logic signed [255:0] num, input int sh,
			input logic signed [255:0] den);
		logic [255:0] a, b, q;
		logic         neg;
		neg = num[255] ^ den[255];
		a = num[255] ? -num : num;
		b = den[255] ? -den : den;
		a = ((a << sh) << 1) + b;
		q = a / (b << 1);
		if (neg) begin
			if (q > 256'(SAT_HI) + 1) q = 256'(SAT_HI) + 1;
			return DW'(-q);
		end
		if (q > 256'(SAT_HI)) q = 256'(SAT_HI);
		return DW'(q);
	endfunction

	task automatic predict_inverse(input logic [IN_TW-1:0] w);
		logic signed [255:0] m[3][3];
		logic signed [255:0] t[3];
		logic signed [255:0] adj[3][3];
		logic signed [255:0] det, acc;
		logic [DW-1:0]       e[3];
		column_t             c;
		logic                sing;
		for (int cc = 0; cc < 3; cc++)
			for (int r = 0; r < 3; r++)
				m[r][cc] = 256'(signed'(w[(cc*3+r)*DW +: DW]));
		for (int r = 0; r < 3; r++) t[r] = 256'(signed'(w[(9+r)*DW +: DW]));
		adj[0][0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
		adj[0][1] = m[0][2]*m[2][1] - m[0][1]*m[2][2];
		adj[0][2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
		adj[1][0] = m[1][2]*m[2][0] - m[1][0]*m[2][2];
		adj[1][1] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
		adj[1][2] = m[0][2]*m[1][0] - m[0][0]*m[1][2];
		adj[2][0] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
		adj[2][1] = m[0][1]*m[2][0] - m[0][0]*m[2][1];
		adj[2][2] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
		det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
		sing = (det == 0);
		for (int cc = 0; cc < 4; cc++) begin
			for (int r = 0; r < 3; r++) begin
				if (sing) e[r] = '0;
				else if (cc < 3) e[r] = quot_round(adj[r][cc], 2*FB, det);
				else begin
					acc = adj[r][0]*t[0] + adj[r][1]*t[1] + adj[r][2]*t[2];
					e[r] = quot_round(-acc, FB, det);
				end
			end
			c.col = 2'(cc); c.x = e[0]; c.y = e[1]; c.z = e[2];
			c.sing = sing; c.last = (cc == 3);
			inverse_q.push_back(c);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0; words_seen = 0; singular_seen = 0; saturated_seen = 0;
	end

	assign pending = inverse_q.size();

	always @(posedge clk) begin
		column_t       c;
		logic [DW-1:0] gx, gy, gz;
		if (arst_n && s_axis_tvalid && s_axis_tready) predict_inverse(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			gx = m_axis_tdata[0 +: DW];
			gy = m_axis_tdata[DW +: DW];
			gz = m_axis_tdata[2*DW +: DW];
			words_seen++;
			if (inverse_q.size() == 0) begin
				report_mismatch("unexpected word, column", DW'(m_axis_tuser[1:0]), '0);
			end else begin
				c = inverse_q.pop_front();
				if (c.sing && c.col == COL_T) singular_seen++;
				if (c.x == SAT_HI || c.x == SAT_LO) saturated_seen++;
				if (m_axis_tuser[1:0] !== c.col)
					report_mismatch("column", DW'(m_axis_tuser[1:0]), DW'(c.col));
				if (m_axis_tuser[2] !== c.sing)
					report_mismatch("singular", DW'(m_axis_tuser[2]), DW'(c.sing));
				if (m_axis_tlast !== c.last)
					report_mismatch("tlast", DW'(m_axis_tlast), DW'(c.last));
				if (gx !== c.x) report_mismatch("out_x", gx, c.x);
				if (gy !== c.y) report_mismatch("out_y", gy, c.y);
				if (gz !== c.z) report_mismatch("out_z", gz, c.z);
			end
		end
	end

endmodule

FILE: tb/sv/affine_transform_inverse_unit_tb.sv
// Testbench top for the affine inverse unit: stimulus, back-pressure and verdict.
module affine_transform_inverse_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import atiu_pkg::*;

	localparam int N_RANDOM = 390;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [DW-1:0] ONE = DW'(1) << FB;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_TW-1:0]    s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_TW-1:0]   m_axis_tdata;
	logic [USR_W-1:0]    m_axis_tuser;
	logic                m_axis_tlast;

	int  fail_count, pending, words_seen, singular_seen, saturated_seen;
	int  cycles = 0;
	int  transforms_sent = 0;
	bit  hold_off = 1'b0;	// long receiver hold-off in force

	always #5 clk = ~clk;

	affine_transform_inverse_unit u_dut (.*);

	atiu_scoreboard u_chk (.*);

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, mostly short, with quiet stretches
	always @(posedge clk) begin
		if (hold_off) m_axis_tready <= 1'b0;
		else if (transforms_sent > 200 && transforms_sent < 260) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 99) < 70);
	end

	// one long receiver hold-off while the sender keeps offering
	initial begin
		wait (transforms_sent == 40);
		hold_off = 1'b1;
		repeat (1500) @(posedge clk);
		hold_off = 1'b0;
	end

	function automatic logic [DW-1:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(DW-1){1'b1}}};
			1: return {1'b1, {(DW-1){1'b0}}};
			2: return '0;
			3: return DW'($urandom_range(0, 2*ONE)) - ONE;	// within +-1.0
			4, 5: return DW'(signed'(DW'($urandom_range(0, 16*ONE))) - signed'(8*ONE));
			default: return DW'($urandom());
		endcase
	endfunction

	function automatic logic [IN_TW-1:0] pack_transform(input logic [DW-1:0] e[12]);
		logic [IN_TW-1:0] w;
		w = '0;
		for (int i = 0; i < 12; i++) w[i*DW +: DW] = e[i];
		return w;
	endfunction

	task automatic send_transform(input logic [IN_TW-1:0] w);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		transforms_sent++;
	endtask

	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	initial begin
		logic [DW-1:0] e[12];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, scaled, singular, extremes, random translations
		for (int k = 0; k < 20; k++) begin
			for (int i = 0; i < 12; i++) e[i] = '0;
			case (k)
				0: begin e[0] = ONE; e[4] = ONE; e[8] = ONE; end
				1: begin e[0] = ONE; e[4] = ONE; e[8] = ONE; e[9] = ONE; e[10] = -ONE; e[11] = 3*ONE; end
				2: begin e[0] = 2*ONE; e[4] = ONE/2; e[8] = -ONE; e[9] = {1'b0, {(DW-1){1'b1}}}; end
				3: ;	// all zero: singular
				4: begin e[0] = ONE; e[1] = 2*ONE; e[3] = 2*ONE; e[4] = 4*ONE; e[8] = ONE; e[9] = ONE; end
				5: begin e[0] = 1; e[4] = 1; e[8] = 1; e[9] = ONE; end	// tiny det: saturates
				6: for (int i = 0; i < 12; i++) e[i] = {1'b1, {(DW-1){1'b0}}};
				7: for (int i = 0; i < 12; i++) e[i] = {1'b0, {(DW-1){1'b1}}};
				8: begin
					e[0] = {1'b1, {(DW-1){1'b0}}}; e[4] = {1'b0, {(DW-1){1'b1}}};
					e[8] = {1'b1, {(DW-1){1'b0}}};
					for (int i = 9; i < 12; i++) e[i] = {1'b1, {(DW-1){1'b0}}};
				end
				9: begin e[3] = ONE; e[1] = ONE; e[8] = ONE; e[11] = -ONE; end	// swap
				10: for (int i = 0; i < 12; i++) e[i] = '1;
				11: begin e[0] = 3*ONE; e[4] = 3*ONE; e[8] = 3*ONE; end	// one-third rounding
				default: for (int i = 0; i < 12; i++) e[i] = rand_entry();
			endcase
			send_transform(pack_transform(e));
			if (k % 4 == 3) sender_gap();
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			for (int i = 0; i < 12; i++) e[i] = rand_entry();
			if ($urandom_range(0, 19) == 0) begin	// dependent columns: singular unless a sum wraps
				e[6] = e[0] + e[3]; e[7] = e[1] + e[4]; e[8] = e[2] + e[5];
			end
			send_transform(pack_transform(e));
			// pause once until everything has drained
			if (n == 100) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end else if (!(n > 180 && n < 240)) sender_gap();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d transforms sent, %0d columns checked", transforms_sent, words_seen);
		$display("%0d singular, %0d saturated x entries", singular_seen, saturated_seen);
		if (fail_count == 0 && pending == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
design/atiu_pkg.sv
design/atiu_front.sv
design/atiu_fifo.sv
design/atiu_div.sv
design/atiu_back.sv
design/affine_transform_inverse_unit.sv
design/atiu_checker.sv
tb/sv/atiu_checker.sv
tb/sv/affine_transform_inverse_unit_tb.sv
